// File: hw/rtl/bilinear_texel_sampler_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the sampler back end (bts_back)
// ---------------------------------------------------------------------------
`ifndef BILINEAR_TEXEL_SAMPLER_UNIT_DEFINES_SVH
`define BILINEAR_TEXEL_SAMPLER_UNIT_DEFINES_SVH
// implication checked every clock, quiet in reset
`define BTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define BTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: hw/rtl/bts_pkg.sv
// ---------------------------------------------------------------------------
// bts_pkg
// Types, constants and helpers for the bilinear texel sampler.
// ---------------------------------------------------------------------------
`default_nettype none
package bts_pkg;
  localparam int MaxSide   = 256;
  localparam int FracBits  = 8;
  localparam int AddrBits  = 16;
  localparam int TexelCount = 1 << AddrBits;
  localparam int SizeBits  = 9;
  localparam int CoordBits = 24;
  localparam int IntBits   = CoordBits - FracBits;  // integer part width
  localparam int QueueDepth = 4;

  typedef enum logic [0:0] {OP_LOAD = 1'b0, OP_SAMPLE = 1'b1} opcode_t;
  typedef enum logic [1:0] {
    REG_WIDTH = 2'd0, REG_HEIGHT = 2'd1, REG_TILE = 2'd2, REG_SMOOTH = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic                         opcode;
    logic [15:0]                  texel_index;
    logic [31:0]                  texel_color;
    logic signed [CoordBits-1:0]  coord_u;
    logic signed [CoordBits-1:0]  coord_v;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } out_word_t;

  // classified request handed from front to back
  typedef struct packed {
    logic                is_load;
    logic [AddrBits-1:0] waddr;
    logic [31:0]         wdata;
    logic [AddrBits-1:0] a0, a1, a2, a3;
    logic [FracBits-1:0] su, sv;
  } req_t;

  // effective size 1..MaxSide, as 9 bits
  function automatic logic [SizeBits-1:0] eff_size(input logic [SizeBits-1:0] s);
    if (s == '0) return SizeBits'(1);
    if (s > SizeBits'(MaxSide)) return SizeBits'(MaxSide);
    return s;
  endfunction
endpackage
`default_nettype wire

// File: hw/rtl/bts_wrap.sv
// ---------------------------------------------------------------------------
// bts_wrap
// Pipelined modulo (tiled) or clamp of a signed integer coordinate by a size of 1..256.
// Four stages, restoring subtract of n<<k per step, fixed latency; all
// stages hold while en is low.
// ---------------------------------------------------------------------------
`default_nettype none
module bts_wrap (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic signed [bts_pkg::IntBits:0]   i,
  input  wire logic [bts_pkg::SizeBits-1:0]       n,
  input  wire logic                               tiled,
  output logic [7:0]                              q
);
  localparam int W = bts_pkg::IntBits + 1;
  localparam int Stages = 4;
  localparam int Per = 5;   // 17-bit magnitude, shifts 16..0 over 4 stages
  localparam int L = Stages - 1;
  logic [W-1:0] mag [Stages];
  logic         neg [Stages];
  logic [bts_pkg::SizeBits-1:0] nn [Stages];
  logic         tl  [Stages];
  logic signed [W-1:0] raw [Stages];
  logic [W-1:0] mag_in;

  // one stage of restoring reduction: subtract n<<sh where it fits
  function automatic logic [W-1:0] reduce(input logic [W-1:0] m_in,
                                          input logic [bts_pkg::SizeBits-1:0] d,
                                          input int s);
    logic [W-1:0] m;
    int sh;
    m = m_in;
    for (int k = 0; k < Per; k++) begin
      sh = (W - 1) - s * Per - k;
      if (sh >= 0) begin
        if ({8'd0, m} >= ({16'd0, d} << sh))
          m = W'({8'd0, m} - ({16'd0, d} << sh));
      end
    end
    return m;
  endfunction

  assign mag_in = i[W-1] ? W'(-i) : W'(i);

  // reduction stages with side data
  always_ff @(posedge clk) begin
    if (en) begin
      mag[0] <= reduce(mag_in, n, 0);
      neg[0] <= i[W-1];
      nn[0]  <= n;
      tl[0]  <= tiled;
      raw[0] <= i;
      for (int s = 1; s < Stages; s++) begin
        mag[s] <= reduce(mag[s-1], nn[s-1], s);
        neg[s] <= neg[s-1];
        nn[s]  <= nn[s-1];
        tl[s]  <= tl[s-1];
        raw[s] <= raw[s-1];
      end
    end
  end

  // final fold: negative remainder moves up by n; clamp path otherwise
  always_comb begin
    logic [bts_pkg::SizeBits-1:0] r;
    r = mag[L][bts_pkg::SizeBits-1:0];
    if (tl[L]) begin
      if (neg[L] && r != '0) r = nn[L] - r;
      q = r[7:0];
    end else if (raw[L] < 0) begin
      q = 8'd0;
    end else if (raw[L] >= $signed({{(W-bts_pkg::SizeBits){1'b0}}, nn[L]})) begin
      q = 8'(nn[L] - bts_pkg::SizeBits'(1));
    end else begin
      q = raw[L][7:0];
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/bts_front.sv
// ---------------------------------------------------------------------------
// bts_front
// Classifies words, finds tap coordinates, wraps/clamps them and builds
// store addresses. Fixed pipeline with a valid bit per stage; it holds when
// the queue to the back end has no room.
// ---------------------------------------------------------------------------
`default_nettype none
module bts_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire bts_pkg::in_word_t             in_word,
  input  wire logic [bts_pkg::SizeBits-1:0]  tex_width,
  input  wire logic [bts_pkg::SizeBits-1:0]  tex_height,
  input  wire logic                          tile_mode,
  input  wire logic                          smooth_mode,
  output logic                               req_valid,
  input  wire logic                          req_ready,
  output bts_pkg::req_t                      req
);
  localparam int IB = bts_pkg::IntBits;
  localparam int WL = 5;  // tap coordinate stage plus the wrap unit stages
  logic [bts_pkg::SizeBits-1:0] w_eff, h_eff;
  logic adv;

  // stage 0: decode and floor
  logic s0_v;
  logic s0_load, s0_smooth;
  logic [15:0] s0_waddr;
  logic [31:0] s0_wdata;
  logic signed [IB:0] s0_bu, s0_bv;
  logic [7:0] s0_su, s0_sv;
  logic signed [bts_pkg::CoordBits:0] fu, fv;

  assign w_eff = bts_pkg::eff_size(tex_width);
  assign h_eff = bts_pkg::eff_size(tex_height);
  // whole pipe moves together; it advances when downstream is ready or the output holds a bubble
  assign adv  = req_ready || !req_valid;
  assign full = !adv;

  always_comb begin
    fu = smooth_mode ? ($signed({in_word.coord_u[23], in_word.coord_u}) - 25'sd128)
                     : $signed({in_word.coord_u[23], in_word.coord_u});
    fv = smooth_mode ? ($signed({in_word.coord_v[23], in_word.coord_v}) - 25'sd128)
                     : $signed({in_word.coord_v[23], in_word.coord_v});
  end

  always_ff @(posedge clk) begin
    if (rst) s0_v <= 1'b0;
    else if (adv) s0_v <= push;
    if (adv) begin
      s0_load   <= (in_word.opcode == bts_pkg::OP_LOAD);
      s0_smooth <= smooth_mode;
      s0_waddr  <= in_word.texel_index;
      s0_wdata  <= in_word.texel_color;
      s0_bu     <= fu[bts_pkg::CoordBits:bts_pkg::FracBits];
      s0_bv     <= fv[bts_pkg::CoordBits:bts_pkg::FracBits];
      s0_su     <= smooth_mode ? fu[7:0] : 8'd0;
      s0_sv     <= smooth_mode ? fv[7:0] : 8'd0;
    end
  end

  // second tap sits one texel past the first in smooth mode
  logic signed [IB:0] bu1, bv1;
  logic [7:0] x0, x1, y0, y1;
  assign bu1 = s0_smooth ? (s0_bu + (IB+1)'(1)) : s0_bu;
  assign bv1 = s0_smooth ? (s0_bv + (IB+1)'(1)) : s0_bv;

  // stage 1: tap coordinates into the wrap units
  logic signed [IB:0] hu0, hu1, hv0, hv1;
  always_ff @(posedge clk) begin
    if (adv) begin
      hu0 <= s0_bu; hu1 <= bu1; hv0 <= s0_bv; hv1 <= bv1;
    end
  end

  // wrap units advance with the rest of the pipe
  bts_wrap u_wx0 (.clk(clk), .en(adv), .i(hu0), .n(w_eff), .tiled(tile_mode), .q(x0));
  bts_wrap u_wx1 (.clk(clk), .en(adv), .i(hu1), .n(w_eff), .tiled(tile_mode), .q(x1));
  bts_wrap u_wy0 (.clk(clk), .en(adv), .i(hv0), .n(h_eff), .tiled(tile_mode), .q(y0));
  bts_wrap u_wy1 (.clk(clk), .en(adv), .i(hv1), .n(h_eff), .tiled(tile_mode), .q(y1));

  // side line (valid, load data, fractions) of matching depth
  logic [WL-1:0] sv_v;
  logic          sd_load [WL];
  logic [15:0]   sd_wa   [WL];
  logic [31:0]   sd_wd   [WL];
  logic [7:0]    sd_su   [WL], sd_sv [WL];
  always_ff @(posedge clk) begin
    if (rst) sv_v <= '0;
    else if (adv) sv_v <= {sv_v[WL-2:0], s0_v};
    if (adv) begin
      sd_load[0] <= s0_load; sd_wa[0] <= s0_waddr; sd_wd[0] <= s0_wdata;
      sd_su[0] <= s0_su; sd_sv[0] <= s0_sv;
      for (int k = 1; k < WL; k++) begin
        sd_load[k] <= sd_load[k-1]; sd_wa[k] <= sd_wa[k-1]; sd_wd[k] <= sd_wd[k-1];
        sd_su[k] <= sd_su[k-1]; sd_sv[k] <= sd_sv[k-1];
      end
    end
  end

  // address: y*w + x, one 8x9 multiply per row
  logic [16:0] r0, r1;
  assign r0 = 17'(y0) * 17'(w_eff);
  assign r1 = 17'(y1) * 17'(w_eff);
  always_comb begin
    req_valid   = sv_v[WL-1];
    req.is_load = sd_load[WL-1];
    req.waddr   = sd_wa[WL-1];
    req.wdata   = sd_wd[WL-1];
    req.su      = sd_su[WL-1];
    req.sv      = sd_sv[WL-1];
    req.a0 = 16'(r0 + 17'(x0));
    req.a1 = 16'(r0 + 17'(x1));
    req.a2 = 16'(r1 + 17'(x0));
    req.a3 = 16'(r1 + 17'(x1));
  end
endmodule
`default_nettype wire

// File: hw/rtl/bts_back.sv
// ---------------------------------------------------------------------------
// bts_back
// Queue of requests, texel store (four read copies), blend and result queue.
// ---------------------------------------------------------------------------
`default_nettype none
`include "bilinear_texel_sampler_unit_defines.svh"
module bts_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire bts_pkg::req_t  req,
  output logic                empty,
  input  wire logic           pop,
  output bts_pkg::out_word_t  out_word
);
  localparam int D = bts_pkg::QueueDepth;
  localparam int PB = $clog2(D);
  localparam int OD = 8;
  localparam int OB = $clog2(OD);

  // request queue
  bts_pkg::req_t rq [D];
  logic [PB-1:0] rq_wp, rq_rp;
  logic [PB:0]   rq_cnt;
  logic rq_push, rq_pop;

  // result queue with credit for words in flight
  bts_pkg::out_word_t oq [OD];
  logic [OB-1:0] oq_wp, oq_rp;
  logic [OB:0]   oq_cnt;
  logic [2:0]    inflight;
  logic oq_push, oq_pop;

  assign req_ready = (rq_cnt != (PB+1)'(D));
  assign rq_push = req_valid && req_ready;
  // issue when a result slot is sure to be free
  assign rq_pop = (rq_cnt != '0) &&
                  ((4'(oq_cnt) + 4'(inflight)) < 4'(OD));

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wp <= '0; rq_rp <= '0; rq_cnt <= '0;
    end else begin
      if (rq_push) rq_wp <= rq_wp + PB'(1);
      if (rq_pop)  rq_rp <= rq_rp + PB'(1);
      rq_cnt <= rq_cnt + (PB+1)'(rq_push) - (PB+1)'(rq_pop);
    end
    if (rq_push) rq[rq_wp] <= req;
  end

  bts_pkg::req_t cur;
  assign cur = rq[rq_rp];

  // texel store: four copies, one read port each, same writes
  logic [31:0] m0 [bts_pkg::TexelCount];
  logic [31:0] m1 [bts_pkg::TexelCount];
  logic [31:0] m2 [bts_pkg::TexelCount];
  logic [31:0] m3 [bts_pkg::TexelCount];
  logic [31:0] p0, p1, p2, p3;
  logic do_wr, do_rd;
  assign do_wr = rq_pop && cur.is_load;
  assign do_rd = rq_pop && !cur.is_load;
  always_ff @(posedge clk) begin
    if (do_wr) begin
      m0[cur.waddr] <= cur.wdata; m1[cur.waddr] <= cur.wdata;
      m2[cur.waddr] <= cur.wdata; m3[cur.waddr] <= cur.wdata;
    end
    p0 <= m0[cur.a0]; p1 <= m1[cur.a1]; p2 <= m2[cur.a2]; p3 <= m3[cur.a3];
  end

  // stage 1: weights
  logic        s1_v, s2_v;
  logic [16:0] w0, w1, w2, w3;
  logic [8:0]  isu, isv;
  always_comb begin
    isu = 9'd256 - 9'(cur.su);
    isv = 9'd256 - 9'(cur.sv);
  end
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0; else s1_v <= do_rd;
    w0 <= 17'(isu) * 17'(isv);
    w1 <= 17'(cur.su) * 17'(isv);
    w2 <= 17'(isu) * 17'(cur.sv);
    w3 <= 17'(cur.su) * 17'(cur.sv);
  end

  // stage 2: per channel products registered
  logic [24:0] pr [4][4];
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0; else s2_v <= s1_v;
    for (int c = 0; c < 4; c++) begin
      pr[c][0] <= 25'(p0[8*c +: 8]) * 25'(w0);
      pr[c][1] <= 25'(p1[8*c +: 8]) * 25'(w1);
      pr[c][2] <= 25'(p2[8*c +: 8]) * 25'(w2);
      pr[c][3] <= 25'(p3[8*c +: 8]) * 25'(w3);
    end
  end

  // stage 3: sum, round, saturate
  logic [7:0] ch [4];
  always_comb begin
    logic [26:0] acc;
    for (int c = 0; c < 4; c++) begin
      acc = 27'd32768 + 27'(pr[c][0]) + 27'(pr[c][1]) + 27'(pr[c][2]) + 27'(pr[c][3]);
      ch[c] = (acc[26:16] > 11'd255) ? 8'hFF : acc[23:16];
    end
  end
  assign oq_push = s2_v;
  assign oq_pop  = pop && !empty;
  assign empty   = (oq_cnt == '0);
  assign out_word = oq[oq_rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wp <= '0; oq_rp <= '0; oq_cnt <= '0; inflight <= '0;
    end else begin
      if (oq_push) oq_wp <= oq_wp + OB'(1);
      if (oq_pop)  oq_rp <= oq_rp + OB'(1);
      oq_cnt <= oq_cnt + (OB+1)'(oq_push) - (OB+1)'(oq_pop);
      inflight <= inflight + 3'(do_rd) - 3'(oq_push);
    end
    if (oq_push) oq[oq_wp] <= '{red: ch[0], green: ch[1], blue: ch[2], alpha: ch[3]};
  end

  `BTS_ASSERT_IMP(a_rq_no_over, rq_cnt == (PB+1)'(D), !rq_push, "request queue overflow")
  `BTS_ASSERT_IMP(a_oq_room, 1'b1, (4'(oq_cnt) + 4'(inflight)) <= 4'(OD), "result credit lost")
  `BTS_ASSERT_NXT(a_pipe, do_rd, s1_v, "sample read not followed")
  `BTS_ASSERT_IMP(a_oq_pop, oq_cnt == '0, !oq_pop, "pop from empty result queue")
endmodule
`default_nettype wire

// File: hw/rtl/bilinear_texel_sampler_unit.sv
// A sample word passes the front pipe, the request queue, the store read, the products register
// and the result queue before it is on the result ports.
// Throughput: one word per cycle; input stalls only while the request queue is full.
// Loads take the same path and make no result.
// Reset (rst, synchronous): size 1x1, clamp, nearest; queues empty; store keeps contents.
// ---------------------------------------------------------------------------
// bilinear_texel_sampler_unit
// Texel sampler: front end computes tap addresses, back end reads and blends.
// ---------------------------------------------------------------------------
`default_nettype none
module bilinear_texel_sampler_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire bts_pkg::in_word_t   in_word,
  output logic                     empty,
  input  wire logic                pop,
  output bts_pkg::out_word_t       out_word,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [8:0]          cfg_data
);
  logic [8:0] tex_width, tex_height;
  logic tile_mode, smooth_mode;
  logic req_valid, req_ready;
  bts_pkg::req_t req;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width <= 9'd1; tex_height <= 9'd1; tile_mode <= 1'b0; smooth_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (bts_pkg::reg_index_t'(cfg_index))
        bts_pkg::REG_WIDTH:  tex_width  <= cfg_data;
        bts_pkg::REG_HEIGHT: tex_height <= cfg_data;
        bts_pkg::REG_TILE:   tile_mode  <= cfg_data[0];
        bts_pkg::REG_SMOOTH: smooth_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bts_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_word(in_word),
    .tex_width(tex_width), .tex_height(tex_height), .tile_mode(tile_mode),
    .smooth_mode(smooth_mode), .req_valid(req_valid), .req_ready(req_ready), .req(req)
  );

  bts_back u_back (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .empty(empty), .pop(pop), .out_word(out_word)
  );
endmodule
`default_nettype wire
